// ----- rtl/pud_pkg.sv -----
// shared types, constants and helper functions of the permissive utf-8 decoder
package pud_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int WC_W   = 2;

  // running width classes
  localparam logic [WC_W-1:0] WC_ONE  = 2'd0;
  localparam logic [WC_W-1:0] WC_TWO  = 2'd1;
  localparam logic [WC_W-1:0] WC_FOUR = 2'd2;

  // lead classes for 2, 3 and 4 byte sequences
  localparam logic [1:0] LC_2B = 2'd0;
  localparam logic [1:0] LC_3B = 2'd1;
  localparam logic [1:0] LC_4B = 2'd2;

  localparam logic [CP_W-1:0] CUT_2B = 21'h0000FF;
  localparam logic [CP_W-1:0] CUT_3B = 21'h00FFFF;

  localparam logic [CP_W-1:0] CH_BACKSLASH = 21'h00005C;
  localparam logic [CP_W-1:0] CH_X         = 21'h000078;
  localparam logic [CP_W-1:0] CH_ZERO      = 21'h000030;
  localparam logic [CP_W-1:0] CH_A         = 21'h000061;

  // work for the back end produced by one accepted byte
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] esc;      // bytes to escape, in order
    logic [2:0]             esc_cnt;  // 0..4
    logic                   has_char; // one decoded character after the escapes
    logic [CP_W-1:0]        cp;
    logic [WC_W-1:0]        cls;
    logic                   is_end;   // end marker closes the list
  } bundle_t;

  function automatic logic [CP_W-1:0] hex_digit(input logic [3:0] v);
    if (v > 4'd9) begin
      hex_digit = CH_A + CP_W'(v - 4'd10);
    end else begin
      hex_digit = CH_ZERO + CP_W'(v);
    end
  endfunction

  function automatic logic [WC_W-1:0] char_width(input logic [1:0] lc,
                                                 input logic [CP_W-1:0] acc);
    case (lc)
      LC_2B:   char_width = (acc > CUT_2B) ? WC_TWO : WC_ONE;
      LC_3B:   char_width = (acc > CUT_3B) ? WC_FOUR : WC_TWO;
      default: char_width = WC_FOUR;
    endcase
  endfunction

endpackage

// ----- rtl/pud_if.sv -----
// valid/ready channel interfaces for the byte input and the character output
interface pud_in_if import pud_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              last_byte;

  modport source(output valid, byte_value, last_byte, input ready);
  modport sink(input valid, byte_value, last_byte, output ready);
endinterface

interface pud_out_if import pud_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            char_valid;
  logic            end_of_string;
  logic [WC_W-1:0] width_class;

  modport source(output valid, code_point, char_valid, end_of_string, width_class,
                 input ready);
  modport sink(input valid, code_point, char_valid, end_of_string, width_class,
               output ready);
endinterface

// ----- rtl/permissive_utf8_decoder_core.sv -----
// Permissive UTF-8 decoder top level. Bytes enter on the bytes channel, one item per
// byte, and decoded characters leave on the chars channel, one item per character,
// escape character or end marker. The front end takes one byte per cycle whenever the
// two-entry queue has room; it tracks the open sequence and turns each byte into a
// bundle of work. The back end delivers one item per cycle from the queue head into
// the output register while the output is not stalled. A byte yields one item for a
// plain or completed character, none for a lead or middle continuation byte, four for
// each escaped byte, one more for the end marker, at most seventeen items in all.
// Long escape bursts fill the queue and hold bytes.ready low; the back-end item rate
// (one per cycle unless chars.ready stalls it) bounds throughput. A byte's first item
// passes a queue slot, then the output register. No clearing pass is needed after reset.
module permissive_utf8_decoder_core import pud_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pud_in_if.sink    bytes,
  pud_out_if.source chars
);

  // front to queue
  logic    push;
  bundle_t push_data;
  logic    space;

  // queue to back
  logic    pop;
  logic    head_valid;
  bundle_t head;

  // sequence tracking and classification
  pud_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .space  (space),
    .push   (push),
    .bundle (push_data)
  );

  // decouples byte intake from item delivery
  pud_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .space      (space),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // escape expansion, running width class and output register
  pud_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .chars      (chars)
  );

endmodule

// ----- rtl/pud_front.sv -----
// front end: sequence tracking and classification of each byte into a work bundle
module pud_front import pud_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  pud_in_if.sink  bytes,
  input  logic    space,
  output logic    push,
  output bundle_t bundle
);

  logic [BYTE_W-1:0] pending [3];
  logic [1:0]        bytes_left;
  logic [1:0]        pend_cnt;
  logic [1:0]        lead_class;
  logic [CP_W-1:0]   code_accumulator;
  logic              stopped_on_nul;

  logic [BYTE_W-1:0] pending_next [3];
  logic [1:0]        bytes_left_next;
  logic [1:0]        pend_cnt_next;
  logic [1:0]        lead_class_next;
  logic [CP_W-1:0]   code_accumulator_next;
  logic              stopped_on_nul_next;
  bundle_t           bnd;
  logic              accept;

  assign bytes.ready = space;
  assign accept      = bytes.valid && space;
  assign bundle      = bnd;
  assign push        = accept && (bnd.esc_cnt != 3'd0 || bnd.has_char || bnd.is_end);

  always_comb begin
    logic              do_lead;
    logic [BYTE_W-1:0] b;
    b                     = bytes.byte_value;
    do_lead               = 1'b0;
    bnd                   = '0;
    pending_next          = pending;
    bytes_left_next       = bytes_left;
    pend_cnt_next         = pend_cnt;
    lead_class_next       = lead_class;
    code_accumulator_next = code_accumulator;
    stopped_on_nul_next   = stopped_on_nul;

    if (!stopped_on_nul) begin
      if (b == 8'h00) begin
        for (int i = 0; i < 3; i++) begin
          if (bytes_left_next != 2'd0 && 2'(i) < pend_cnt_next) begin
            bnd.esc[bnd.esc_cnt[1:0]] = pending_next[i];
            bnd.esc_cnt               = bnd.esc_cnt + 3'd1;
          end
        end
        bytes_left_next     = 2'd0;
        pend_cnt_next       = 2'd0;
        stopped_on_nul_next = 1'b1;
      end else if (bytes_left == 2'd0) begin
        do_lead = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        // continuation byte
        if (pend_cnt != 2'd3) begin
          pending_next[pend_cnt] = b;
          pend_cnt_next          = pend_cnt + 2'd1;
        end
        bytes_left_next       = bytes_left - 2'd1;
        code_accumulator_next = {code_accumulator[CP_W-7:0], b[5:0]};
        if (bytes_left_next == 2'd0) begin
          bnd.has_char = 1'b1;
          bnd.cp       = code_accumulator_next;
          bnd.cls      = char_width(lead_class, code_accumulator_next);
        end
      end else begin
        // missing continuation: escape what is pending, then retry as lead
        for (int i = 0; i < 3; i++) begin
          if (bytes_left_next != 2'd0 && 2'(i) < pend_cnt_next) begin
            bnd.esc[bnd.esc_cnt[1:0]] = pending_next[i];
            bnd.esc_cnt               = bnd.esc_cnt + 3'd1;
          end
        end
        bytes_left_next = 2'd0;
        pend_cnt_next   = 2'd0;
        do_lead         = 1'b1;
      end
    end

    if (do_lead) begin
      if (!b[7]) begin
        bnd.has_char = 1'b1;
        bnd.cp       = CP_W'(b);
        bnd.cls      = WC_ONE;
      end else if (b[7:5] == 3'b110) begin
        bytes_left_next       = 2'd1;
        lead_class_next       = LC_2B;
        code_accumulator_next = CP_W'(b[4:0]);
        pend_cnt_next         = 2'd1;
        pending_next[0]       = b;
      end else if (b[7:4] == 4'b1110) begin
        bytes_left_next       = 2'd2;
        lead_class_next       = LC_3B;
        code_accumulator_next = CP_W'(b[3:0]);
        pend_cnt_next         = 2'd1;
        pending_next[0]       = b;
      end else if (b[7:3] == 5'b11110) begin
        bytes_left_next       = 2'd3;
        lead_class_next       = LC_4B;
        code_accumulator_next = CP_W'(b[2:0]);
        pend_cnt_next         = 2'd1;
        pending_next[0]       = b;
      end else begin
        bnd.esc[bnd.esc_cnt[1:0]] = b;
        bnd.esc_cnt               = bnd.esc_cnt + 3'd1;
        bytes_left_next           = 2'd0;
      end
    end

    if (bytes.last_byte) begin
      for (int i = 0; i < 3; i++) begin
        if (bytes_left_next != 2'd0 && 2'(i) < pend_cnt_next) begin
          bnd.esc[bnd.esc_cnt[1:0]] = pending_next[i];
          bnd.esc_cnt               = bnd.esc_cnt + 3'd1;
        end
      end
      bnd.is_end            = 1'b1;
      bytes_left_next       = 2'd0;
      pend_cnt_next         = 2'd0;
      lead_class_next       = LC_2B;
      code_accumulator_next = '0;
      stopped_on_nul_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left       <= 2'd0;
      pend_cnt         <= 2'd0;
      lead_class       <= LC_2B;
      code_accumulator <= '0;
      stopped_on_nul   <= 1'b0;
    end else if (accept) begin
      bytes_left       <= bytes_left_next;
      pend_cnt         <= pend_cnt_next;
      lead_class       <= lead_class_next;
      code_accumulator <= code_accumulator_next;
      stopped_on_nul   <= stopped_on_nul_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending <= pending_next;
    end
  end

endmodule

// ----- rtl/pud_queue.sv -----
// two-entry bundle queue between front and back end
module pud_queue import pud_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    space,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  bundle_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign space      = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/pud_back.sv -----
// back end: expands bundles into output register items, one per cycle while not stalled
module pud_back import pud_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  bundle_t   head,
  output logic      pop,
  pud_out_if.source chars
);

  localparam logic [1:0] DIG_BSL = 2'd0;
  localparam logic [1:0] DIG_X   = 2'd1;
  localparam logic [1:0] DIG_HI  = 2'd2;
  localparam logic [1:0] DIG_LO  = 2'd3;

  logic [2:0]        pos;
  logic [1:0]        dig;
  logic              char_done;
  logic [WC_W-1:0]   width_run;

  logic              advance;
  logic              in_esc;
  logic              in_char;
  logic              last_res;
  logic [BYTE_W-1:0] esc_byte;
  logic [WC_W-1:0]   char_w;
  logic [CP_W-1:0]   res_cp;
  logic              res_char;
  logic              res_end;
  logic [WC_W-1:0]   res_width;

  assign advance  = head_valid && (!chars.valid || chars.ready);
  assign in_esc   = (pos < head.esc_cnt);
  assign in_char  = !in_esc && head.has_char && !char_done;
  assign esc_byte = head.esc[pos[1:0]];
  assign char_w   = (head.cls > width_run) ? head.cls : width_run;
  assign pop      = advance && last_res;

  always_comb begin
    res_cp    = '0;
    res_char  = 1'b1;
    res_end   = 1'b0;
    res_width = width_run;
    last_res  = 1'b1;
    if (in_esc) begin
      case (dig)
        DIG_BSL: res_cp = CH_BACKSLASH;
        DIG_X:   res_cp = CH_X;
        DIG_HI:  res_cp = hex_digit(esc_byte[7:4]);
        default: res_cp = hex_digit(esc_byte[3:0]);
      endcase
      last_res = (dig == DIG_LO) && ((pos + 3'd1) == head.esc_cnt) &&
                 !head.has_char && !head.is_end;
    end else if (in_char) begin
      res_cp    = head.cp;
      res_width = char_w;
      last_res  = !head.is_end;
    end else begin
      // end marker
      res_char = 1'b0;
      res_end  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      pos         <= 3'd0;
      dig         <= DIG_BSL;
      char_done   <= 1'b0;
      width_run   <= WC_ONE;
    end else if (advance) begin
      chars.valid <= 1'b1;
      if (last_res) begin
        pos       <= 3'd0;
        dig       <= DIG_BSL;
        char_done <= 1'b0;
      end else if (in_esc) begin
        dig <= dig + 2'd1;
        if (dig == DIG_LO) begin
          pos <= pos + 3'd1;
        end
      end else begin
        char_done <= 1'b1;
      end
      if (in_char) begin
        width_run <= char_w;
      end else if (!in_esc) begin
        width_run <= WC_ONE;
      end
    end else if (chars.ready) begin
      chars.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      chars.code_point    <= res_cp;
      chars.char_valid    <= res_char;
      chars.end_of_string <= res_end;
      chars.width_class   <= res_width;
    end
  end

endmodule

// ----- rtl/pud_checker.sv -----
// port-level checks on the decoder output channel, bound to the top level
module pud_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [20:0] code_point,
  input logic        char_valid,
  input logic        end_of_string,
  input logic [1:0]  width_class
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("output item dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    valid |-> (char_valid ^ end_of_string))
    else $error("item is neither a character nor an end marker");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    valid && end_of_string |-> code_point == 21'd0)
    else $error("end marker carries a code point");

  a_width: assert property (@(posedge clk) disable iff (rst)
    valid |-> width_class != 2'd3)
    else $error("width class out of range");

endmodule

bind permissive_utf8_decoder_core pud_checker u_pud_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (chars.valid),
  .ready         (chars.ready),
  .code_point    (chars.code_point),
  .char_valid    (chars.char_valid),
  .end_of_string (chars.end_of_string),
  .width_class   (chars.width_class)
);
